// ----- rtl/sst_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants for the scoped symbol table
// Request codes, sequencer states and the packed row attribute layout.
// ----------------------------------------------------------------------------
package sst_pkg;

  // Default sizing for the top level
  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_KEY_BITS    = 32;

  // Fixed field widths of the item ports
  localparam int REQ_W   = 3;
  localparam int KEY_IN_W = 32;
  localparam int CODE_W  = 2;
  localparam int VAL_W   = 16;
  localparam int ROW_W   = 8;

  // Symbol kind that marks a function row
  localparam logic [CODE_W-1:0] KIND_FUNCTION = 2'd2;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT       = 3'd0,
    REQ_LOOKUP_ALL   = 3'd1,
    REQ_LOOKUP_LOCAL = 3'd2,
    REQ_ENTER        = 3'd3,
    REQ_EXIT         = 3'd4
  } req_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ENTER_RD,
    ST_FINISH
  } state_t;

  // Row attributes as held in the attribute store (36 bits)
  typedef struct packed {
    logic [VAL_W-1:0]  extra;
    logic [VAL_W-1:0]  offset;
    logic [CODE_W-1:0] kind;
    logic [CODE_W-1:0] scope;
  } attr_t;

endpackage
`default_nettype wire

// ----- rtl/sst_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sst_store: key and attribute storage
// One write port and one read port with registered read data, shared by the
// key array and the attribute array at the same row.
// ----------------------------------------------------------------------------
module sst_store #(
  parameter int DEPTH = 256,
  parameter int KEY_W = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [KEY_W-1:0]         wr_key,
  input  wire sst_pkg::attr_t           wr_attr,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [KEY_W-1:0]         rd_key,
  output sst_pkg::attr_t                rd_attr
);
  import sst_pkg::*;

  logic [KEY_W-1:0] key_mem [DEPTH];
  attr_t            attr_mem [DEPTH];

  // Write the new row
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= wr_key;
      attr_mem[wr_addr] <= wr_attr;
    end
  end

  // Read one row, hold the data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key  <= key_mem[rd_addr];
      rd_attr <= attr_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/scoped_symbol_table_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scoped_symbol_table_top: stack-ordered symbol table with one scope base
// Insert, full lookup, local lookup, enter-function and exit-function requests
// over a row store, answered one item at a time.
// ----------------------------------------------------------------------------
// One request is taken at a time and in_ready stays low until its result is
// in the output register. A lookup steps the single read port of the row
// store one row per cycle while the key comparator checks the row read in
// the cycle before, so a hit ends the search early. A full lookup walks from
// the newest row down, a local lookup from the scope base up. An insert is
// refused with table_full when the table holds TABLE_DEPTH-1 rows.
// The next request may be taken while a result still waits on out_ready.
// ----------------------------------------------------------------------------
module scoped_symbol_table_top #(
  parameter int TABLE_DEPTH = sst_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = sst_pkg::DEF_KEY_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [31:0] in_key,
  input  wire logic [1:0]  in_scope_kind,
  input  wire logic [1:0]  in_sym_kind,
  input  wire logic [15:0] in_offset,
  input  wire logic [15:0] in_extra_count,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_found,
  output logic [7:0]       out_entry_index,
  output logic [1:0]       out_hit_scope,
  output logic [1:0]       out_hit_kind,
  output logic [15:0]      out_hit_offset,
  output logic [15:0]      out_hit_extra,
  output logic             out_table_full,
  output logic             out_in_function,
  output logic [7:0]       out_function_index
);
  import sst_pkg::*;

  localparam int PTR_W = $clog2(TABLE_DEPTH);
  localparam logic [PTR_W-1:0] TOP_MAX = PTR_W'(TABLE_DEPTH - 1);

  // Sequencer and table state
  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   top_ptr_r, top_ptr_nxt;
  logic [PTR_W-1:0]   base_r, base_nxt;
  logic               func_r, func_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [PTR_W-1:0]   addr_r, addr_nxt;
  logic [PTR_W-1:0]   rem_r, rem_nxt;
  logic               dir_up_r, dir_up_nxt;
  logic               q_vld_r, q_vld_nxt;
  logic [PTR_W-1:0]   q_row_r, q_row_nxt;

  // Result staging
  logic               res_found_r, res_found_nxt;
  logic [PTR_W-1:0]   res_row_r, res_row_nxt;
  attr_t              res_attr_r, res_attr_nxt;
  logic               res_full_r, res_full_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [ROW_W-1:0]   out_row_r, out_row_nxt;
  attr_t              out_attr_r, out_attr_nxt;
  logic               out_full_r, out_full_nxt;
  logic               out_func_r, out_func_nxt;
  logic [ROW_W-1:0]   out_fidx_r, out_fidx_nxt;

  // Store ports
  logic                wr_en;
  logic                rd_en;
  logic [PTR_W-1:0]    rd_addr;
  logic [KEY_BITS-1:0] rd_key;
  attr_t               rd_attr;
  attr_t               in_attr;
  logic [KEY_BITS-1:0] in_key_m;
  logic [PTR_W-1:0]    func_row;

  assign in_ready = (state_r == ST_IDLE);
  assign in_key_m = KEY_BITS'(in_key);
  assign func_row = base_r - PTR_W'(1);

  always_comb begin
    in_attr        = '0;
    in_attr.scope  = in_scope_kind;
    in_attr.kind   = in_sym_kind;
    in_attr.offset = in_offset;
    in_attr.extra  = in_extra_count;
  end

  sst_store #(
    .DEPTH (TABLE_DEPTH),
    .KEY_W (KEY_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (top_ptr_r),
    .wr_key  (in_key_m),
    .wr_attr (in_attr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_attr (rd_attr)
  );

  // Next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    top_ptr_nxt   = top_ptr_r;
    base_nxt      = base_r;
    func_nxt      = func_r;
    key_nxt       = key_r;
    addr_nxt      = addr_r;
    rem_nxt       = rem_r;
    dir_up_nxt    = dir_up_r;
    q_vld_nxt     = 1'b0;
    q_row_nxt     = q_row_r;
    res_found_nxt = res_found_r;
    res_row_nxt   = res_row_r;
    res_attr_nxt  = res_attr_r;
    res_full_nxt  = res_full_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_row_nxt   = out_row_r;
    out_attr_nxt  = out_attr_r;
    out_full_nxt  = out_full_r;
    out_func_nxt  = out_func_r;
    out_fidx_nxt  = out_fidx_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = addr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          // default to a miss, overridden below
          res_found_nxt = 1'b0;
          res_row_nxt   = '0;
          res_attr_nxt  = '0;
          res_full_nxt  = 1'b0;
          state_nxt     = ST_FINISH;
          unique case (in_req_type)
            REQ_INSERT: begin
              if (top_ptr_r == TOP_MAX) begin
                res_full_nxt = 1'b1;
              end else begin
                wr_en         = 1'b1;
                res_found_nxt = 1'b1;
                res_row_nxt   = top_ptr_r;
                res_attr_nxt  = in_attr;
                top_ptr_nxt   = top_ptr_r + PTR_W'(1);
              end
            end
            REQ_LOOKUP_ALL: begin
              key_nxt    = in_key_m;
              addr_nxt   = top_ptr_r - PTR_W'(1);
              rem_nxt    = top_ptr_r;
              dir_up_nxt = 1'b0;
              state_nxt  = ST_SCAN;
            end
            REQ_LOOKUP_LOCAL: begin
              key_nxt    = in_key_m;
              addr_nxt   = base_r;
              rem_nxt    = top_ptr_r - base_r;
              dir_up_nxt = 1'b1;
              state_nxt  = ST_SCAN;
            end
            REQ_ENTER: begin
              base_nxt = top_ptr_r;
              if (top_ptr_r != '0) begin
                rd_en     = 1'b1;
                rd_addr   = top_ptr_r - PTR_W'(1);
                state_nxt = ST_ENTER_RD;
              end else begin
                func_nxt = 1'b0;
              end
            end
            REQ_EXIT: begin
              top_ptr_nxt = base_r;
              base_nxt    = '0;
              func_nxt    = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        // compare the row read last cycle, issue the next one
        if (q_vld_r && (rd_key == key_r)) begin
          res_found_nxt = 1'b1;
          res_row_nxt   = q_row_r;
          res_attr_nxt  = rd_attr;
          state_nxt     = ST_FINISH;
        end else if (rem_r != '0) begin
          rd_en     = 1'b1;
          rd_addr   = addr_r;
          q_vld_nxt = 1'b1;
          q_row_nxt = addr_r;
          addr_nxt  = dir_up_r ? (addr_r + PTR_W'(1)) : (addr_r - PTR_W'(1));
          rem_nxt   = rem_r - PTR_W'(1);
        end else begin
          state_nxt = ST_FINISH;
        end
      end

      ST_ENTER_RD: begin
        func_nxt  = (rd_attr.kind == KIND_FUNCTION);
        state_nxt = ST_FINISH;
      end

      ST_FINISH: begin
        // move the result into the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_row_nxt   = ROW_W'(res_row_r);
          out_attr_nxt  = res_attr_r;
          out_full_nxt  = res_full_r;
          out_func_nxt  = func_r;
          out_fidx_nxt  = func_r ? ROW_W'(func_row) : '0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      top_ptr_r   <= '0;
      base_r      <= '0;
      func_r      <= 1'b0;
      q_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_ptr_r   <= top_ptr_nxt;
      base_r      <= base_nxt;
      func_r      <= func_nxt;
      q_vld_r     <= q_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    addr_r      <= addr_nxt;
    rem_r       <= rem_nxt;
    dir_up_r    <= dir_up_nxt;
    q_row_r     <= q_row_nxt;
    res_found_r <= res_found_nxt;
    res_row_r   <= res_row_nxt;
    res_attr_r  <= res_attr_nxt;
    res_full_r  <= res_full_nxt;
    out_found_r <= out_found_nxt;
    out_row_r   <= out_row_nxt;
    out_attr_r  <= out_attr_nxt;
    out_full_r  <= out_full_nxt;
    out_func_r  <= out_func_nxt;
    out_fidx_r  <= out_fidx_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_entry_index    = out_row_r;
  assign out_hit_scope      = out_attr_r.scope;
  assign out_hit_kind       = out_attr_r.kind;
  assign out_hit_offset     = out_attr_r.offset;
  assign out_hit_extra      = out_attr_r.extra;
  assign out_table_full     = out_full_r;
  assign out_in_function    = out_func_r;
  assign out_function_index = out_fidx_r;

`ifndef SYNTHESIS
  // The scope base never rises above the top of the stack
  a_base_le_top: assert property (@(posedge clk) disable iff (!rst_n)
    base_r <= top_ptr_r)
    else $error("scope base above top pointer");

  // A current function needs a base above row zero
  a_func_base: assert property (@(posedge clk) disable iff (!rst_n)
    func_r |-> (base_r != '0))
    else $error("function flagged at global scope");

  // An accepted insert that is not refused pushes exactly one row
  a_insert_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_req_type == REQ_INSERT) && (top_ptr_r != TOP_MAX))
    |=> (top_ptr_r == $past(top_ptr_r) + PTR_W'(1)))
    else $error("insert did not advance top pointer");

  // A refused insert never reports a row
  a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> !out_found)
    else $error("refused insert reported as found");
`endif

endmodule
`default_nettype wire

// ----- sim/scoped_symbol_table_top_test.sv -----
// ----------------------------------------------------------------------------
// scoped_symbol_table_top_test: self-checking bench for the scoped symbol table
// Drives insert, lookup, enter and exit requests through the valid/ready
// ports. A scoreboard class keeps its own copy of the row store and the scope
// pointers, predicts each result and compares every field of it. Pacing
// changes between phases, and the table is filled once until inserts are
// refused.
// ----------------------------------------------------------------------------
module scoped_symbol_table_top_test;
  import sst_pkg::*;

  localparam int DEPTH       = DEF_TABLE_DEPTH;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int POOL_SIZE   = 16;

  // Request codes that the block leaves unused
  localparam logic [REQ_W-1:0] REQ_SPARE_LO  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_MID = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI  = 3'd7;

  // Scope and symbol kind codes
  localparam logic [CODE_W-1:0] SCOPE_GLOBAL = 2'd0;
  localparam logic [CODE_W-1:0] SCOPE_ARG    = 2'd1;
  localparam logic [CODE_W-1:0] SCOPE_LOCAL  = 2'd2;
  localparam logic [CODE_W-1:0] KIND_INT     = 2'd0;
  localparam logic [CODE_W-1:0] KIND_ARRAY   = 2'd1;
  localparam logic [CODE_W-1:0] CODE_SPARE   = 2'd3;

  typedef struct packed {
    logic              found;
    logic [ROW_W-1:0]  entry_index;
    logic [CODE_W-1:0] hit_scope;
    logic [CODE_W-1:0] hit_kind;
    logic [VAL_W-1:0]  hit_offset;
    logic [VAL_W-1:0]  hit_extra;
    logic              table_full;
    logic              in_function;
    logic [ROW_W-1:0]  function_index;
  } sym_result_t;

  // Table predictor and store of expected results
  class symtab_scoreboard;
    logic [KEY_IN_W-1:0] key_mem [DEPTH];
    attr_t               attr_mem [DEPTH];
    int                  top_ptr;
    int                  scope_base;
    sym_result_t         expected_q[$];
    int                  errors;
    int                  checked;
    int                  hits;
    int                  refused;
    int                  func_results;

    function new();
      top_ptr    = 0;
      scope_base = 0;
      errors     = 0;
      checked    = 0;
      hits       = 0;
      refused    = 0;
      func_results = 0;
    endfunction

    function sym_result_t row_hit(int row);
      sym_result_t r;
      r             = '0;
      r.found       = 1'b1;
      r.entry_index = row[ROW_W-1:0];
      r.hit_scope   = attr_mem[row].scope;
      r.hit_kind    = attr_mem[row].kind;
      r.hit_offset  = attr_mem[row].offset;
      r.hit_extra   = attr_mem[row].extra;
      return r;
    endfunction

    // Apply one accepted request to the table copy and queue its result
    function void note_request(logic [REQ_W-1:0] req, logic [KEY_IN_W-1:0] key,
                               logic [CODE_W-1:0] sc, logic [CODE_W-1:0] kd,
                               logic [VAL_W-1:0] off, logic [VAL_W-1:0] ex);
      sym_result_t r;
      int i;
      r = '0;
      case (req)
        REQ_INSERT: begin
          if (top_ptr + 1 >= DEPTH) begin
            r.table_full = 1'b1;
            refused++;
          end else begin
            key_mem[top_ptr]  = key;
            attr_mem[top_ptr] = '{extra: ex, offset: off, kind: kd, scope: sc};
            r = row_hit(top_ptr);
            top_ptr++;
          end
        end
        REQ_LOOKUP_ALL: begin
          for (i = top_ptr - 1; i >= 0; i--) begin
            if (key_mem[i] == key) begin
              r = row_hit(i);
              hits++;
              break;
            end
          end
        end
        REQ_LOOKUP_LOCAL: begin
          for (i = scope_base; i < top_ptr; i++) begin
            if (key_mem[i] == key) begin
              r = row_hit(i);
              hits++;
              break;
            end
          end
        end
        REQ_ENTER: scope_base = top_ptr;
        REQ_EXIT: begin
          top_ptr    = scope_base;
          scope_base = 0;
        end
        default: ;
      endcase
      // A function is current when the row under the base is a function
      if (scope_base > 0 && attr_mem[scope_base - 1].kind == KIND_FUNCTION) begin
        r.in_function    = 1'b1;
        r.function_index = ROW_W'(scope_base - 1);
        func_results++;
      end
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [VAL_W-1:0] exp_v,
                                logic [VAL_W-1:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, got_v);
      end
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(sym_result_t got);
      sym_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare_field("found", VAL_W'(want.found), VAL_W'(got.found));
      compare_field("entry_index", VAL_W'(want.entry_index), VAL_W'(got.entry_index));
      compare_field("hit_scope", VAL_W'(want.hit_scope), VAL_W'(got.hit_scope));
      compare_field("hit_kind", VAL_W'(want.hit_kind), VAL_W'(got.hit_kind));
      compare_field("hit_offset", want.hit_offset, got.hit_offset);
      compare_field("hit_extra", want.hit_extra, got.hit_extra);
      compare_field("table_full", VAL_W'(want.table_full), VAL_W'(got.table_full));
      compare_field("in_function", VAL_W'(want.in_function), VAL_W'(got.in_function));
      compare_field("function_index", VAL_W'(want.function_index),
                    VAL_W'(got.function_index));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [REQ_W-1:0]  in_req_type = '0;
  logic [31:0]       in_key = '0;
  logic [1:0]        in_scope_kind = '0;
  logic [1:0]        in_sym_kind = '0;
  logic [15:0]       in_offset = '0;
  logic [15:0]       in_extra_count = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_found;
  logic [7:0]        out_entry_index;
  logic [1:0]        out_hit_scope;
  logic [1:0]        out_hit_kind;
  logic [15:0]       out_hit_offset;
  logic [15:0]       out_hit_extra;
  logic              out_table_full;
  logic              out_in_function;
  logic [7:0]        out_function_index;

  symtab_scoreboard  sb = new();
  int                cycle_count = 0;
  int                items_sent = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                hold_req = 0;
  int                hold_seen = 0;
  int                hold_left = 0;
  logic [31:0]       key_pool [POOL_SIZE];

  scoped_symbol_table_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_key             (in_key),
    .in_scope_kind      (in_scope_kind),
    .in_sym_kind        (in_sym_kind),
    .in_offset          (in_offset),
    .in_extra_count     (in_extra_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found          (out_found),
    .out_entry_index    (out_entry_index),
    .out_hit_scope      (out_hit_scope),
    .out_hit_kind       (out_hit_kind),
    .out_hit_offset     (out_hit_offset),
    .out_hit_extra      (out_hit_extra),
    .out_table_full     (out_table_full),
    .out_in_function    (out_in_function),
    .out_function_index (out_function_index)
  );

  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.expected_q.size());
      $display("scoped_symbol_table_top verification failed");
      $finish;
    end
  end

  // Drive out_ready: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Check every result item taken on the output
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_found, out_entry_index, out_hit_scope, out_hit_kind,
                       out_hit_offset, out_hit_extra, out_table_full,
                       out_in_function, out_function_index});
  end

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 99) < 85)
      return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Offer one item, idling first as the current pacing asks, and hold it until taken
  task automatic send_req(input logic [REQ_W-1:0] req, input logic [31:0] key,
                          input logic [1:0] sc, input logic [1:0] kd,
                          input logic [15:0] off, input logic [15:0] ex);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_key         <= key;
    in_scope_kind  <= sc;
    in_sym_kind    <= kd;
    in_offset      <= off;
    in_extra_count <= ex;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    sb.note_request(req, key, sc, kd, off, ex);
    items_sent++;
  endtask

  // Offer one item whose insert-only fields carry random noise
  task automatic send_noise(input logic [REQ_W-1:0] req, input logic [31:0] key);
    logic [31:0] rnd_a;
    logic [31:0] rnd_b;
    rnd_a = $urandom;
    rnd_b = $urandom;
    send_req(req, key, rnd_a[1:0], rnd_a[3:2], rnd_a[31:16], rnd_b[15:0]);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0)
      @(posedge clk);
    @(posedge clk);
  endtask

  // Mostly well-formed function bodies, some global declarations, some noise
  task automatic random_traffic(input int n_items);
    int start;
    int choice;
    int n_args;
    int n_locals;
    int n_looks;
    int i;
    start = items_sent;
    while (items_sent - start < n_items) begin
      // keep scans short: unwind to global scope and clear the table
      if (sb.top_ptr > 48) begin
        send_noise(REQ_EXIT, $urandom);
        send_noise(REQ_EXIT, $urandom);
      end
      choice = $urandom_range(0, 99);
      if (choice < 55) begin
        n_args   = $urandom_range(0, 3);
        n_locals = $urandom_range(0, 3);
        n_looks  = $urandom_range(2, 5);
        send_req(REQ_INSERT, pick_key(), SCOPE_GLOBAL, KIND_FUNCTION,
                 VAL_W'($urandom_range(0, 65535)), VAL_W'(n_args));
        send_noise(REQ_ENTER, $urandom);
        for (i = 0; i < n_args; i++)
          send_req(REQ_INSERT, pick_key(), SCOPE_ARG, KIND_INT,
                   VAL_W'($urandom_range(0, 65535)), 16'd0);
        for (i = 0; i < n_locals; i++) begin
          if ($urandom_range(0, 1) == 0)
            send_req(REQ_INSERT, pick_key(), SCOPE_LOCAL, KIND_INT,
                     VAL_W'($urandom_range(0, 65535)), 16'd0);
          else
            send_req(REQ_INSERT, pick_key(), SCOPE_LOCAL, KIND_ARRAY,
                     VAL_W'($urandom_range(0, 65535)), VAL_W'($urandom_range(1, 65535)));
        end
        for (i = 0; i < n_looks; i++) begin
          if ($urandom_range(0, 1) == 0)
            send_noise(REQ_LOOKUP_ALL, pick_key());
          else
            send_noise(REQ_LOOKUP_LOCAL, pick_key());
        end
        // now and then open a further scope inside the body
        if ($urandom_range(0, 99) < 15) begin
          send_noise(REQ_ENTER, $urandom);
          send_req(REQ_INSERT, pick_key(), SCOPE_LOCAL, KIND_INT,
                   VAL_W'($urandom_range(0, 65535)), 16'd0);
          send_noise(REQ_LOOKUP_LOCAL, pick_key());
        end
        // leave a body unclosed now and then
        if ($urandom_range(0, 99) < 90)
          send_noise(REQ_EXIT, $urandom);
      end else if (choice < 75) begin
        n_locals = $urandom_range(1, 3);
        for (i = 0; i < n_locals; i++)
          send_req(REQ_INSERT, pick_key(), SCOPE_GLOBAL, CODE_W'($urandom_range(0, 1)),
                   VAL_W'($urandom_range(0, 65535)), VAL_W'($urandom_range(0, 65535)));
        send_noise(REQ_LOOKUP_ALL, pick_key());
      end else begin
        send_noise(REQ_W'($urandom_range(0, 7)), pick_key());
      end
    end
  endtask

  initial begin : stimulus
    logic [31:0] deep_key;
    int i;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (i = 2; i < POOL_SIZE; i++)
      key_pool[i] = $urandom;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, field extremes, shadowing, nested scopes, spare codes
    send_req(REQ_LOOKUP_ALL, 32'h0, SCOPE_GLOBAL, KIND_INT, 16'h0, 16'h0);
    send_req(REQ_EXIT, 32'h0, SCOPE_GLOBAL, KIND_INT, 16'h0, 16'h0);
    send_req(REQ_INSERT, 32'h0, SCOPE_GLOBAL, KIND_INT, 16'h0, 16'h0);
    send_req(REQ_INSERT, 32'hFFFF_FFFF, CODE_SPARE, CODE_SPARE, 16'hFFFF, 16'hFFFF);
    send_req(REQ_INSERT, 32'hA5A5_5A5A, SCOPE_GLOBAL, KIND_FUNCTION, 16'h1234, 16'd2);
    send_req(REQ_LOOKUP_ALL, 32'h0, SCOPE_GLOBAL, KIND_INT, 16'h0, 16'h0);
    send_req(REQ_LOOKUP_ALL, 32'hFFFF_FFFF, SCOPE_GLOBAL, KIND_INT, 16'h0, 16'h0);
    send_req(REQ_ENTER, 32'h0, SCOPE_GLOBAL, KIND_INT, 16'h0, 16'h0);
    send_req(REQ_INSERT, 32'h0, SCOPE_ARG, KIND_INT, 16'h8, 16'h0);
    send_req(REQ_INSERT, 32'h11, SCOPE_LOCAL, KIND_ARRAY, 16'h10, 16'd10);
    send_req(REQ_LOOKUP_ALL, 32'h0, SCOPE_GLOBAL, KIND_INT, 16'h0, 16'h0);
    send_req(REQ_LOOKUP_LOCAL, 32'h0, SCOPE_GLOBAL, KIND_INT, 16'h0, 16'h0);
    send_req(REQ_LOOKUP_LOCAL, 32'hFFFF_FFFF, SCOPE_GLOBAL, KIND_INT, 16'h0, 16'h0);
    send_req(REQ_LOOKUP_ALL, 32'hFFFF_FFFF, SCOPE_GLOBAL, KIND_INT, 16'h0, 16'h0);
    // enter while inside a function: the base moves over a non-function row
    send_req(REQ_ENTER, 32'h0, SCOPE_GLOBAL, KIND_INT, 16'h0, 16'h0);
    send_req(REQ_INSERT, 32'h22, SCOPE_GLOBAL, CODE_SPARE, 16'h40, 16'd3);
    // kind 3 under the base does not count as a function
    send_req(REQ_ENTER, 32'h0, SCOPE_GLOBAL, KIND_INT, 16'h0, 16'h0);
    send_req(REQ_SPARE_LO, 32'h22, CODE_SPARE, CODE_SPARE, 16'hFFFF, 16'hFFFF);
    send_req(REQ_SPARE_MID, 32'hFFFF_FFFF, SCOPE_ARG, KIND_ARRAY, 16'h5555, 16'hAAAA);
    send_req(REQ_SPARE_HI, 32'h0, SCOPE_LOCAL, KIND_FUNCTION, 16'hAAAA, 16'h5555);
    send_req(REQ_EXIT, 32'h0, SCOPE_GLOBAL, KIND_INT, 16'h0, 16'h0);
    send_req(REQ_LOOKUP_LOCAL, 32'h0, SCOPE_GLOBAL, KIND_INT, 16'h0, 16'h0);
    send_req(REQ_EXIT, 32'h0, SCOPE_GLOBAL, KIND_INT, 16'h0, 16'h0);
    send_req(REQ_LOOKUP_ALL, 32'h0, SCOPE_GLOBAL, KIND_INT, 16'h0, 16'h0);
    pause_until_drained();

    // No idling; hold the receiver off long enough for the input to back up
    hold_req <= hold_req + 1;
    random_traffic(80);
    pause_until_drained();

    // Sender mostly idle
    send_idle_pct = 77;
    random_traffic(60);
    pause_until_drained();

    // Receiver mostly stalled
    send_idle_pct = 0;
    recv_stall_pct <= 77;
    random_traffic(60);
    pause_until_drained();

    // Light idling on both sides; fill the table until inserts are refused
    send_idle_pct = 8;
    recv_stall_pct <= 8;
    send_noise(REQ_EXIT, $urandom);
    send_noise(REQ_EXIT, $urandom);
    deep_key = $urandom;
    send_req(REQ_INSERT, deep_key, SCOPE_GLOBAL, KIND_ARRAY,
             VAL_W'($urandom), VAL_W'($urandom));
    while (sb.top_ptr + 1 < DEPTH)
      send_noise(REQ_INSERT, pick_key());
    send_noise(REQ_INSERT, pick_key());
    send_req(REQ_INSERT, deep_key, SCOPE_GLOBAL, KIND_FUNCTION,
             VAL_W'($urandom), VAL_W'($urandom));
    send_noise(REQ_LOOKUP_ALL, deep_key);
    send_noise(REQ_LOOKUP_LOCAL, $urandom);
    send_noise(REQ_LOOKUP_ALL, pick_key());
    send_noise(REQ_ENTER, $urandom);
    send_req(REQ_INSERT, pick_key(), SCOPE_LOCAL, KIND_INT,
             VAL_W'($urandom), VAL_W'($urandom));
    send_noise(REQ_LOOKUP_LOCAL, pick_key());
    send_noise(REQ_EXIT, $urandom);
    send_noise(REQ_EXIT, $urandom);
    random_traffic(40);

    // Drain, then give any stray result time to show up
    pause_until_drained();
    repeat (DEPTH + 8) @(posedge clk);

    $display("Sent %0d requests under four pacing modes, one receiver hold-off and a full table.",
             items_sent);
    $display("Checked %0d results: %0d lookup hits, %0d refused inserts, %0d inside a function.",
             sb.checked, sb.hits, sb.refused, sb.func_results);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("scoped_symbol_table_top verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.expected_q.size());
      $display("scoped_symbol_table_top verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sst_pkg.sv
rtl/sst_store.sv
rtl/scoped_symbol_table_top.sv
sim/scoped_symbol_table_top_test.sv
